@@ hw/rtl/knn_pkg.sv @@
// Shared types and fixed field widths for the k-nearest-neighbor classifier.
`timescale 1ns / 1ps
package knn_pkg;

  localparam int VALUE_W     = 16;
  localparam int LABEL_W     = 4;
  localparam int NUM_CLASSES = 16;
  localparam int SIDX_W      = 10;
  localparam int FIDX_W      = 4;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int USED_W      = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_NEIGHBOR_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_METRIC_SELECT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FEATURE_COUNT  = 2'd3;

  localparam logic OP_TRAIN = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic METRIC_EUCLID    = 1'b0;
  localparam logic METRIC_MANHATTAN = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIST = 6'b000010,
    ST_SEL  = 6'b000100,
    ST_VOTE = 6'b001000,
    ST_MAJ  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

endpackage

@@ hw/rtl/k_nearest_neighbor_classifier.sv @@
// Top level of the k-nearest-neighbor classifier.
//
//  channel  | dir | payload                                             | beat
//  in_      | in  | tuser: op; tdata: row_idx, feature_index,           | tvalid & tready
//           |     |   value, train_label                                |
//  out_     | out | tdata: class_label, neighbors_used                  | tvalid & tready
//  cfg_     | in  | cfg_addr register index, cfg_data value             | cfg_we
//
// A training or non-final query beat is taken while idle. A final query beat starts
// distance work (one feature RAM read per cycle), then selection (one distance RAM
// scan per neighbor), then majority search and a load of the result register; with no
// samples only the last two.
// Reset is synchronous, active low; no clearing pass is needed.
// in_tready is low while a query is evaluated; the result register waits on out_tready.
`timescale 1ns / 1ps
module k_nearest_neighbor_classifier
  import knn_pkg::*;
#(
  parameter int MAX_SAMPLES  = 1024,
  parameter int MAX_FEATURES = 16,
  parameter int MAX_K        = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [9:0] row_idx, [13:10] feature_index, [29:14] value, [33:30] train_label
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] op
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [3:0] class_label, [8:4] neighbors_used
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int S_W    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SC_W   = $clog2(MAX_SAMPLES + 1);
  localparam int F_W    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int FA_D   = MAX_SAMPLES * MAX_FEATURES;
  localparam int FA_W   = (FA_D > 1) ? $clog2(FA_D) : 1;
  localparam int K_W    = $clog2(MAX_K + 1);
  localparam int DIFF_W = VALUE_W + 1;
  localparam int TERM_W = 2 * DIFF_W;
  localparam int DIST_W = TERM_W + ((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 0);
  localparam int CLS_W  = $clog2(NUM_CLASSES);

  // Configuration registers
  logic [4:0]  neighbor_count_r;
  logic        metric_select_r;
  logic [10:0] sample_count_r;
  logic [4:0]  feature_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neighbor_count_r <= 5'd3;
      metric_select_r  <= METRIC_EUCLID;
      sample_count_r   <= 11'd0;
      feature_count_r  <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NEIGHBOR_COUNT: neighbor_count_r <= cfg_data[4:0];
        REG_METRIC_SELECT:  metric_select_r  <= cfg_data[0];
        REG_SAMPLE_COUNT:   sample_count_r   <= cfg_data;
        REG_FEATURE_COUNT:  feature_count_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Effective counts after capping
  logic [SC_W-1:0] ns;
  logic [F_W:0]    nf;
  logic [K_W-1:0]  k_eff;
  logic [K_W-1:0]  k_use;

  always_comb begin
    ns = SC_W'((32'(sample_count_r) > MAX_SAMPLES) ? MAX_SAMPLES : 32'(sample_count_r));
    if (feature_count_r == 5'd0) begin
      nf = (F_W+1)'(1);
    end else begin
      nf = (F_W+1)'((32'(feature_count_r) > MAX_FEATURES) ? MAX_FEATURES
                                                           : 32'(feature_count_r));
    end
    if (neighbor_count_r == 5'd0) begin
      k_eff = K_W'(1);
    end else begin
      k_eff = K_W'((32'(neighbor_count_r) > MAX_K) ? MAX_K : 32'(neighbor_count_r));
    end
    k_use = (32'(k_eff) > 32'(ns)) ? K_W'(ns) : k_eff;
  end

  // Input field unpacking
  logic                     in_op;
  logic [SIDX_W-1:0]        in_sample_index;
  logic [FIDX_W-1:0]        in_feature_index;
  logic signed [VALUE_W-1:0] in_value;
  logic [LABEL_W-1:0]       in_train_label;

  assign in_op            = in_tuser;
  assign in_sample_index  = in_tdata[9:0];
  assign in_feature_index = in_tdata[13:10];
  assign in_value         = in_tdata[29:14];
  assign in_train_label   = in_tdata[33:30];

  state_t state_r;
  logic   in_beat;
  logic   train_we;
  logic   query_in_range;
  logic   query_last;

  assign in_tready      = (state_r == ST_IDLE);
  assign in_beat        = in_tvalid && in_tready;
  assign train_we       = in_beat && (in_op == OP_TRAIN) &&
                          (32'(in_sample_index) < MAX_SAMPLES) &&
                          (32'(in_feature_index) < MAX_FEATURES);
  assign query_in_range = (32'(in_feature_index) < MAX_FEATURES);
  assign query_last     = in_beat && (in_op == OP_QUERY) &&
                          (32'(in_feature_index) == 32'(nf) - 1);

  // Query vector held in flops
  logic [VALUE_W-1:0] qvec_r [MAX_FEATURES];

  always_ff @(posedge clk) begin
    if (in_beat && (in_op == OP_QUERY) && query_in_range) begin
      qvec_r[F_W'(in_feature_index)] <= in_value;
    end
  end

  // Memories
  logic [FA_W-1:0]    feat_waddr;
  logic               feat_re;
  logic [FA_W-1:0]    feat_raddr;
  logic [VALUE_W-1:0] feat_rdata;
  logic               dist_we;
  logic [S_W-1:0]     dist_waddr;
  logic [DIST_W-1:0]  dist_wdata;
  logic               sel_re;
  logic [S_W-1:0]     sel_raddr;
  logic [DIST_W-1:0]  dist_rdata;
  logic [LABEL_W-1:0] label_rdata;

  assign feat_waddr = FA_W'(32'(in_sample_index) * MAX_FEATURES + 32'(in_feature_index));

  knn_ram #(.WIDTH(VALUE_W), .DEPTH(FA_D)) u_feat_ram (
    .clk, .we(train_we), .waddr(feat_waddr), .wdata(in_value),
    .re(feat_re), .raddr(feat_raddr), .rdata(feat_rdata)
  );

  knn_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_SAMPLES)) u_label_ram (
    .clk, .we(train_we), .waddr(S_W'(in_sample_index)), .wdata(in_train_label),
    .re(sel_re), .raddr(sel_raddr), .rdata(label_rdata)
  );

  knn_ram #(.WIDTH(DIST_W), .DEPTH(MAX_SAMPLES)) u_dist_ram (
    .clk, .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .re(sel_re), .raddr(sel_raddr), .rdata(dist_rdata)
  );

  // Distance pipeline: issue, difference and square or absolute value, accumulate
  logic            iss_busy_r;
  logic [S_W-1:0]  iss_s_r;
  logic [F_W-1:0]  iss_f_r;
  logic [FA_W-1:0] base_r;
  logic            iss_last_f;
  logic            p1_valid_r, p1_first_r, p1_last_r;
  logic [F_W-1:0]  p1_f_r;
  logic [S_W-1:0]  p1_s_r;
  logic            p2_valid_r, p2_first_r, p2_last_r;
  logic [S_W-1:0]  p2_s_r;
  logic [TERM_W-1:0] term_r;
  logic [DIST_W-1:0] acc_r, acc_nxt;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] abs_diff;

  assign iss_last_f = (32'(iss_f_r) == 32'(nf) - 1);
  assign feat_re    = (state_r == ST_DIST) && iss_busy_r;
  assign feat_raddr = base_r + FA_W'(iss_f_r);

  always_comb begin
    diff     = $signed({qvec_r[p1_f_r][VALUE_W-1], qvec_r[p1_f_r]}) -
               $signed({feat_rdata[VALUE_W-1], feat_rdata});
    abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    acc_nxt  = (p2_first_r ? '0 : acc_r) + DIST_W'(term_r);
  end

  assign dist_we    = p2_valid_r && p2_last_r;
  assign dist_waddr = p2_s_r;
  assign dist_wdata = acc_nxt;

  // Selection scan and vote state
  logic              scan_busy_r;
  logic [S_W-1:0]    scan_s_r;
  logic              r_valid_r;
  logic [S_W-1:0]    r_s_r;
  logic              first_pick_r;
  logic [DIST_W-1:0] prev_d_r;
  logic [S_W-1:0]    prev_s_r;
  logic              found_r;
  logic [DIST_W-1:0] best_d_r;
  logic [S_W-1:0]    best_s_r;
  logic [LABEL_W-1:0] best_label_r;
  logic [K_W-1:0]    pick_r;
  logic [K_W-1:0]    votes_r [NUM_CLASSES];
  logic [CLS_W-1:0]  cls_r;
  logic [K_W-1:0]    best_cnt_r;
  logic [CLS_W-1:0]  maj_label_r;
  logic              cand;
  logic              out_valid_r;
  logic [LABEL_W-1:0] out_label_r;
  logic [USED_W-1:0] out_used_r;

  assign sel_re    = (state_r == ST_SEL) && scan_busy_r;
  assign sel_raddr = scan_s_r;
  assign cand      = first_pick_r || (dist_rdata > prev_d_r) ||
                     ((dist_rdata == prev_d_r) && (r_s_r > prev_s_r));

  // Control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_busy_r  <= 1'b0;
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      scan_busy_r <= 1'b0;
      r_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= feat_re;
      p2_valid_r <= p1_valid_r;
      r_valid_r  <= sel_re;
      // raise the result on a load, drop it once taken
      if ((state_r == ST_OUT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (query_last) begin
            iss_busy_r <= (ns != '0);
            state_r    <= (ns != '0) ? ST_DIST : ST_MAJ;
          end
        end
        ST_DIST: begin
          if (iss_busy_r && iss_last_f && (32'(iss_s_r) == 32'(ns) - 1)) begin
            iss_busy_r <= 1'b0;
          end
          if (p2_valid_r && p2_last_r && (32'(p2_s_r) == 32'(ns) - 1)) begin
            scan_busy_r <= 1'b1;
            state_r     <= ST_SEL;
          end
        end
        ST_SEL: begin
          if (scan_busy_r && (32'(scan_s_r) == 32'(ns) - 1)) begin
            scan_busy_r <= 1'b0;
          end
          if (r_valid_r && (32'(r_s_r) == 32'(ns) - 1)) begin
            state_r <= ST_VOTE;
          end
        end
        ST_VOTE: begin
          if (pick_r == k_use - K_W'(1)) begin
            state_r <= ST_MAJ;
          end else begin
            scan_busy_r <= 1'b1;
            state_r     <= ST_SEL;
          end
        end
        ST_MAJ: begin
          if (32'(cls_r) == NUM_CLASSES - 1) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // start of a query: reset counters and votes
    if (query_last) begin
      iss_s_r      <= '0;
      iss_f_r      <= '0;
      base_r       <= '0;
      scan_s_r     <= '0;
      first_pick_r <= 1'b1;
      found_r      <= 1'b0;
      pick_r       <= '0;
      cls_r        <= '0;
      best_cnt_r   <= '0;
      maj_label_r  <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        votes_r[c] <= '0;
      end
    end

    // advance issue position
    if (feat_re) begin
      if (iss_last_f) begin
        iss_f_r <= '0;
        iss_s_r <= iss_s_r + S_W'(1);
        base_r  <= base_r + FA_W'(MAX_FEATURES);
      end else begin
        iss_f_r <= iss_f_r + F_W'(1);
      end
    end
    p1_f_r     <= iss_f_r;
    p1_s_r     <= iss_s_r;
    p1_first_r <= (iss_f_r == '0);
    p1_last_r  <= iss_last_f;

    // difference, then square or absolute value
    p2_s_r     <= p1_s_r;
    p2_first_r <= p1_first_r;
    p2_last_r  <= p1_last_r;
    term_r     <= (metric_select_r == METRIC_MANHATTAN) ? TERM_W'(abs_diff)
                                                        : TERM_W'(abs_diff) * TERM_W'(abs_diff);
    if (p2_valid_r) begin
      acc_r <= acc_nxt;
    end

    // scan for the next nearest sample above the previous pick
    if (sel_re) begin
      scan_s_r <= scan_s_r + S_W'(1);
    end
    r_s_r <= scan_s_r;
    if (r_valid_r && cand && (!found_r || (dist_rdata < best_d_r))) begin
      found_r      <= 1'b1;
      best_d_r     <= dist_rdata;
      best_s_r     <= r_s_r;
      best_label_r <= label_rdata;
    end

    // count the pick's vote and prepare the next scan
    if (state_r == ST_VOTE) begin
      votes_r[best_label_r] <= votes_r[best_label_r] + K_W'(1);
      prev_d_r     <= best_d_r;
      prev_s_r     <= best_s_r;
      first_pick_r <= 1'b0;
      found_r      <= 1'b0;
      scan_s_r     <= '0;
      pick_r       <= pick_r + K_W'(1);
    end

    // majority search, lower label wins ties
    if (state_r == ST_MAJ) begin
      if (votes_r[cls_r] > best_cnt_r) begin
        best_cnt_r  <= votes_r[cls_r];
        maj_label_r <= cls_r;
      end
      cls_r <= cls_r + CLS_W'(1);
    end

    // load the result register
    if ((state_r == ST_OUT) && (!out_valid_r || out_tready)) begin
      out_label_r <= LABEL_W'(maj_label_r);
      out_used_r  <= USED_W'(k_use);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-USED_W-LABEL_W){1'b0}}, out_used_r, out_label_r};

endmodule

@@ hw/rtl/knn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module knn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/knn_checker.sv @@
// Port-level assertions for the k-nearest-neighbor classifier, bound to the top level.
`timescale 1ns / 1ps
module knn_checker
  import knn_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_we,
  input logic [CFG_ADDR_W-1:0]  cfg_addr,
  input logic [CFG_DATA_W-1:0]  cfg_data
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // No result right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A training beat never produces a result
  a_train_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_TRAIN) && !out_tvalid |=> !out_tvalid)
    else $error("result appeared after a training beat");

  // Neighbor count in a result stays within the cap
  a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:4] <= 5'd16)
    else $error("neighbors_used above cap");

endmodule

bind k_nearest_neighbor_classifier knn_checker u_knn_checker (.*);
